>>> src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/crfs_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package crfs_pkg;

   localparam int MAX_RULES = 16;
   localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W     = $clog2(MAX_RULES + 1);

   localparam logic [2:0] CSR_RULE_COUNT   = 3'd0;
   localparam logic [2:0] CSR_GROUP_TOPO   = 3'd1;
   localparam logic [2:0] CSR_GROUP_LAYERS = 3'd2;
   localparam logic [2:0] CSR_DEFAULT_ALGO = 3'd3;
   localparam logic [2:0] CSR_TOPO_INVALID = 3'd4;
   localparam logic [2:0] CSR_TOPO_WILD    = 3'd5;

   typedef enum logic [2:0] {
      OP_WR_ATTR   = 3'd0,
      OP_WR_RANK   = 3'd1,
      OP_WR_LAYERS = 3'd2,
      OP_WR_BYTES  = 3'd3,
      OP_SELECT    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_NARROW,
      ST_PICK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             accept;
      logic             scan_rd;
      logic             pick_rd;
      logic             narrow;
      logic             load_rsp;
      logic [IDX_W-1:0] rd_idx;
   } cmd_type;

   typedef struct packed {
      logic             req_select;
      logic             rsp_free;
      logic [CNT_W-1:0] n_rules;
   } sts_type;

endpackage

>>> src/crfs_ctrl.sv
// Controller: sequences table scan, filter narrowing, priority pick and result load.
module crfs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  crfs_pkg::sts_type sts,
   output crfs_pkg::cmd_type cmd
);

   crfs_pkg::state_type             state_ff, state_in;
   logic [crfs_pkg::CNT_W-1:0]      idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crfs_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      req_stall  = 1'b1;
      cmd        = '0;
      cmd.rd_idx = idx_ff[crfs_pkg::IDX_W-1:0];
      case (state_ff)
         crfs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.req_select) begin
                  idx_in   = '0;
                  state_in = crfs_pkg::ST_SCAN;
               end
            end
         end
         crfs_pkg::ST_SCAN: begin
            if (idx_ff < sts.n_rules) begin
               cmd.scan_rd = 1'b1;
               idx_in      = idx_ff + 1'b1;
            end else begin
               state_in = crfs_pkg::ST_NARROW;
            end
         end
         crfs_pkg::ST_NARROW: begin
            cmd.narrow = 1'b1;
            idx_in     = '0;
            state_in   = crfs_pkg::ST_PICK;
         end
         crfs_pkg::ST_PICK: begin
            if (idx_ff < sts.n_rules) begin
               cmd.pick_rd = 1'b1;
               idx_in      = idx_ff + 1'b1;
            end else begin
               state_in = crfs_pkg::ST_FINISH;
            end
         end
         crfs_pkg::ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = crfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crfs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/crfs_dp.sv
// Datapath: rule table, configuration registers, match vectors, pick and result register.
module crfs_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  crfs_pkg::cmd_type           cmd,
   output crfs_pkg::sts_type           sts,
   input  logic                 [2:0]  req_operation,
   input  logic                 [3:0]  req_slot,
   input  logic                 [7:0]  req_rule_engine,
   input  logic                 [31:0] req_rule_topology,
   input  logic signed          [15:0] req_rule_priority,
   input  logic                 [7:0]  req_rule_algo,
   input  logic                 [63:0] req_low_bound,
   input  logic                 [63:0] req_high_bound,
   input  logic                 [7:0]  req_request_engine,
   input  logic                 [15:0] req_rank_size,
   input  logic                 [63:0] req_data_bytes,
   input  logic                        csr_wr_en,
   input  logic                 [2:0]  csr_index,
   input  logic                 [31:0] csr_wdata,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                 [7:0]  rsp_selected_algo,
   output logic                        rsp_fell_back,
   output logic                 [4:0]  rsp_survivors
);

   localparam int N = crfs_pkg::MAX_RULES;

   // configuration
   logic [4:0]  rule_count_ff;
   logic [31:0] group_topo_ff;
   logic [3:0]  group_layers_ff;
   logic [7:0]  default_algo_ff;
   logic [31:0] topo_invalid_ff;
   logic [31:0] topo_wild_ff;

   // rule table
   logic        [7:0]  mem_engine   [N];
   logic        [31:0] mem_topo     [N];
   logic signed [15:0] mem_prio     [N];
   logic        [7:0]  mem_algo     [N];
   logic        [15:0] mem_rank_lo  [N];
   logic        [15:0] mem_rank_hi  [N];
   logic        [3:0]  mem_lay_lo   [N];
   logic        [3:0]  mem_lay_hi   [N];
   logic        [63:0] mem_bytes_lo [N];
   logic        [63:0] mem_bytes_hi [N];

   logic        [7:0]  rd_engine_ff;
   logic        [31:0] rd_topo_ff;
   logic signed [15:0] rd_prio_ff;
   logic        [7:0]  rd_algo_ff;
   logic        [15:0] rd_rank_lo_ff;
   logic        [15:0] rd_rank_hi_ff;
   logic        [3:0]  rd_lay_lo_ff;
   logic        [3:0]  rd_lay_hi_ff;
   logic        [63:0] rd_bytes_lo_ff;
   logic        [63:0] rd_bytes_hi_ff;

   logic [crfs_pkg::IDX_W-1:0] wr_idx;
   logic                       wr_ok;
   logic [15:0]                sat_rank_lo, sat_rank_hi;
   logic [3:0]                 sat_lay_lo, sat_lay_hi;

   // select request
   logic [7:0]  sel_engine_ff;
   logic [15:0] sel_ranks_ff;
   logic [63:0] sel_bytes_ff;

   // scan and pick
   logic                       scan_v_ff, pick_v_ff;
   logic [crfs_pkg::IDX_W-1:0] idx_d_ff;
   logic [N-1:0]               cand_ff, cand_in;
   logic [N-1:0]               m_eng_ff, m_rank_ff, m_lay_ff, m_topo_ff, m_bytes_ff;
   logic                       hit_eng, hit_rank, hit_lay, hit_topo, hit_bytes;
   logic [crfs_pkg::CNT_W-1:0] count_ff;
   logic                       found_ff;
   logic signed [15:0]         best_prio_ff;
   logic [7:0]                 best_algo_ff;

   logic                       rsp_valid_ff;
   logic [7:0]                 rsp_algo_ff;
   logic                       rsp_fb_ff;
   logic [4:0]                 rsp_surv_ff;

   function automatic logic [N-1:0] narrow(input logic [N-1:0] cand,
                                           input logic [N-1:0] match);
      logic [N-1:0] kept;
      kept = cand & match;
      return (kept != '0) ? kept : cand;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff   <= '0;
         group_topo_ff   <= 32'hFFFF_FFFF;
         group_layers_ff <= '0;
         default_algo_ff <= '0;
         topo_invalid_ff <= 32'hFFFF_FFFF;
         topo_wild_ff    <= 32'hFFFF_FFFE;
      end else if (csr_wr_en) begin
         case (csr_index)
            crfs_pkg::CSR_RULE_COUNT:   rule_count_ff   <= csr_wdata[4:0];
            crfs_pkg::CSR_GROUP_TOPO:   group_topo_ff   <= csr_wdata;
            crfs_pkg::CSR_GROUP_LAYERS: group_layers_ff <= csr_wdata[3:0];
            crfs_pkg::CSR_DEFAULT_ALGO: default_algo_ff <= csr_wdata[7:0];
            crfs_pkg::CSR_TOPO_INVALID: topo_invalid_ff <= csr_wdata;
            crfs_pkg::CSR_TOPO_WILD:    topo_wild_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign wr_idx      = crfs_pkg::IDX_W'(req_slot);
   assign wr_ok       = (32'(req_slot) < 32'(N));
   assign sat_rank_lo = (req_low_bound[63:16] != '0)  ? 16'hFFFF : req_low_bound[15:0];
   assign sat_rank_hi = (req_high_bound[63:16] != '0) ? 16'hFFFF : req_high_bound[15:0];
   assign sat_lay_lo  = (req_low_bound[63:4] != '0)   ? 4'hF : req_low_bound[3:0];
   assign sat_lay_hi  = (req_high_bound[63:4] != '0)  ? 4'hF : req_high_bound[3:0];

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_ok) begin
         case (req_operation)
            crfs_pkg::OP_WR_ATTR: begin
               mem_engine[wr_idx] <= req_rule_engine;
               mem_topo[wr_idx]   <= req_rule_topology;
               mem_prio[wr_idx]   <= req_rule_priority;
               mem_algo[wr_idx]   <= req_rule_algo;
            end
            crfs_pkg::OP_WR_RANK: begin
               mem_rank_lo[wr_idx] <= sat_rank_lo;
               mem_rank_hi[wr_idx] <= sat_rank_hi;
            end
            crfs_pkg::OP_WR_LAYERS: begin
               mem_lay_lo[wr_idx] <= sat_lay_lo;
               mem_lay_hi[wr_idx] <= sat_lay_hi;
            end
            crfs_pkg::OP_WR_BYTES: begin
               mem_bytes_lo[wr_idx] <= req_low_bound;
               mem_bytes_hi[wr_idx] <= req_high_bound;
            end
            default: ;
         endcase
      end
      rd_engine_ff   <= mem_engine[cmd.rd_idx];
      rd_topo_ff     <= mem_topo[cmd.rd_idx];
      rd_prio_ff     <= mem_prio[cmd.rd_idx];
      rd_algo_ff     <= mem_algo[cmd.rd_idx];
      rd_rank_lo_ff  <= mem_rank_lo[cmd.rd_idx];
      rd_rank_hi_ff  <= mem_rank_hi[cmd.rd_idx];
      rd_lay_lo_ff   <= mem_lay_lo[cmd.rd_idx];
      rd_lay_hi_ff   <= mem_lay_hi[cmd.rd_idx];
      rd_bytes_lo_ff <= mem_bytes_lo[cmd.rd_idx];
      rd_bytes_hi_ff <= mem_bytes_hi[cmd.rd_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sel_engine_ff <= req_request_engine;
         sel_ranks_ff  <= req_rank_size;
         sel_bytes_ff  <= req_data_bytes;
      end
      idx_d_ff <= cmd.rd_idx;
   end

   assign hit_eng   = (rd_engine_ff == 8'd0) || (rd_engine_ff == sel_engine_ff);
   assign hit_rank  = (sel_ranks_ff >= rd_rank_lo_ff) && (sel_ranks_ff <= rd_rank_hi_ff);
   assign hit_lay   = (group_layers_ff == 4'd0) ||
                      ((rd_lay_lo_ff <= group_layers_ff) && (rd_lay_hi_ff >= group_layers_ff));
   assign hit_topo  = (group_topo_ff == topo_invalid_ff) || (rd_topo_ff == topo_wild_ff) ||
                      (rd_topo_ff == group_topo_ff);
   assign hit_bytes = (sel_bytes_ff >= rd_bytes_lo_ff) && (sel_bytes_ff <= rd_bytes_hi_ff);

   always_comb begin
      cand_in = cand_ff;
      cand_in = narrow(cand_in, m_eng_ff);
      cand_in = narrow(cand_in, m_rank_ff);
      cand_in = narrow(cand_in, m_lay_ff);
      cand_in = narrow(cand_in, m_topo_ff);
      cand_in = narrow(cand_in, m_bytes_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_v_ff <= 1'b0;
         pick_v_ff <= 1'b0;
      end else begin
         scan_v_ff <= cmd.scan_rd;
         pick_v_ff <= cmd.pick_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cand_ff    <= '0;
         m_eng_ff   <= '0;
         m_rank_ff  <= '0;
         m_lay_ff   <= '0;
         m_topo_ff  <= '0;
         m_bytes_ff <= '0;
      end else if (scan_v_ff) begin
         cand_ff[idx_d_ff]    <= 1'b1;
         m_eng_ff[idx_d_ff]   <= hit_eng;
         m_rank_ff[idx_d_ff]  <= hit_rank;
         m_lay_ff[idx_d_ff]   <= hit_lay;
         m_topo_ff[idx_d_ff]  <= hit_topo;
         m_bytes_ff[idx_d_ff] <= hit_bytes;
      end else if (cmd.narrow) begin
         cand_ff <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.narrow) begin
         count_ff <= '0;
         found_ff <= 1'b0;
      end else if (pick_v_ff && cand_ff[idx_d_ff]) begin
         count_ff <= count_ff + 1'b1;
         found_ff <= 1'b1;
         if (!found_ff || (rd_prio_ff > best_prio_ff)) begin
            best_prio_ff <= rd_prio_ff;
            best_algo_ff <= rd_algo_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (found_ff) begin
            rsp_algo_ff <= best_algo_ff;
            rsp_fb_ff   <= 1'b0;
            rsp_surv_ff <= 5'(count_ff);
         end else begin
            rsp_algo_ff <= default_algo_ff;
            rsp_fb_ff   <= 1'b1;
            rsp_surv_ff <= '0;
         end
      end
   end

   assign sts.req_select = (req_operation == crfs_pkg::OP_SELECT);
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign sts.n_rules    = (32'(rule_count_ff) > 32'(N)) ? crfs_pkg::CNT_W'(N)
                                                         : crfs_pkg::CNT_W'(rule_count_ff);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_selected_algo = rsp_algo_ff;
   assign rsp_fell_back     = rsp_fb_ff;
   assign rsp_survivors     = rsp_surv_ff;

endmodule

>>> src/cascaded_rule_filter_selector.sv
// Top level: rule table selector, controller plus datapath.
// Table writes (operations 0 to 3) are accepted back to back. A select
// stalls further requests until its result is loaded; the rule count is
// capped at the table depth. The single table read port is walked once to
// build the five match vectors, the cascade of filters is then applied in
// the narrow state, and the port is walked again for the priority pick and
// survivor count. The result sits in an output register, so writes are
// still accepted while it waits; a following select waits for that register
// to drain before finishing.
module cascaded_rule_filter_selector (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic        [2:0]  req_operation,
   input  logic        [3:0]  req_slot,
   input  logic        [7:0]  req_rule_engine,
   input  logic        [31:0] req_rule_topology,
   input  logic signed [15:0] req_rule_priority,
   input  logic        [7:0]  req_rule_algo,
   input  logic        [63:0] req_low_bound,
   input  logic        [63:0] req_high_bound,
   input  logic        [7:0]  req_request_engine,
   input  logic        [15:0] req_rank_size,
   input  logic        [63:0] req_data_bytes,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [7:0]  rsp_selected_algo,
   output logic               rsp_fell_back,
   output logic        [4:0]  rsp_survivors,
   input  logic               csr_wr_en,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_wdata
);

   crfs_pkg::cmd_type cmd;
   crfs_pkg::sts_type sts;

   crfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   crfs_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_operation      (req_operation),
      .req_slot           (req_slot),
      .req_rule_engine    (req_rule_engine),
      .req_rule_topology  (req_rule_topology),
      .req_rule_priority  (req_rule_priority),
      .req_rule_algo      (req_rule_algo),
      .req_low_bound      (req_low_bound),
      .req_high_bound     (req_high_bound),
      .req_request_engine (req_request_engine),
      .req_rank_size      (req_rank_size),
      .req_data_bytes     (req_data_bytes),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_selected_algo  (rsp_selected_algo),
      .rsp_fell_back      (rsp_fell_back),
      .rsp_survivors      (rsp_survivors)
   );

endmodule

>>> src/crfs_checker.sv
// Port-level checker for the selector, bound to the top level.
`include "assert_macros.svh"

module crfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_selected_algo,
   input logic        rsp_fell_back,
   input logic [4:0]  rsp_survivors
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_selected_algo) && $stable(rsp_fell_back) && $stable(rsp_survivors))
   `ASSERT_IMPLIES(a_fallback_empty, clock, reset, rsp_valid && rsp_fell_back, rsp_survivors == 5'd0)
   `ASSERT_IMPLIES(a_pick_nonempty, clock, reset, rsp_valid && !rsp_fell_back, rsp_survivors != 5'd0)
   `ASSERT_NEXT(a_select_busy, clock, reset, req_valid && !req_stall && (req_operation == crfs_pkg::OP_SELECT), req_stall)

endmodule

bind cascaded_rule_filter_selector crfs_checker u_crfs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_operation     (req_operation),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_selected_algo (rsp_selected_algo),
   .rsp_fell_back     (rsp_fell_back),
   .rsp_survivors     (rsp_survivors)
);
